FILE: design/hpt_pkg.sv
// Shared constants, codes and types of the homogeneous point transform.
package hpt_pkg;

	localparam int FIELD_WIDTH    = 48;
	localparam int SLOT_WIDTH     = 5;
	localparam int MAX_WIDTH      = 64;
	localparam int DATA_WIDTH_DEF = 48;
	localparam int FRAC_BITS_DEF  = 16;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_POINT = 1'b1;

	// Slot map: matrix entries first, then origin x, y, z
	localparam logic [SLOT_WIDTH-1:0] SLOT_ORIGIN_X = 5'd16;
	localparam logic [SLOT_WIDTH-1:0] SLOT_END      = 5'd19;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_WZERO = 2'd1,
		ST_OVF   = 2'd2
	} status_t;

	typedef struct packed {
		logic       point;
		logic       wzero;
		logic [2:0] neg;
		logic [2:0] ovf;
	} meta_t;

endpackage

FILE: design/hpt_in_if.sv
// Request channel: coefficient loads and points.
interface hpt_in_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    op;
	logic        [hpt_pkg::SLOT_WIDTH-1:0]   slot;
	logic signed [hpt_pkg::FIELD_WIDTH-1:0]  coef_value;
	logic signed [hpt_pkg::FIELD_WIDTH-1:0]  point_x;
	logic signed [hpt_pkg::FIELD_WIDTH-1:0]  point_y;
	logic signed [hpt_pkg::FIELD_WIDTH-1:0]  point_z;

	modport source (output valid, op, slot, coef_value, point_x, point_y, point_z,
		input ready);
	modport sink (input valid, op, slot, coef_value, point_x, point_y, point_z,
		output ready);
endinterface

FILE: design/hpt_out_if.sv
// Response channel: status and transformed coordinates.
interface hpt_out_if;
	logic                                    valid;
	logic                                    ready;
	logic        [1:0]                       status;
	logic signed [hpt_pkg::FIELD_WIDTH-1:0]  real_x;
	logic signed [hpt_pkg::FIELD_WIDTH-1:0]  real_y;
	logic signed [hpt_pkg::FIELD_WIDTH-1:0]  real_z;

	modport source (output valid, status, real_x, real_y, real_z, input ready);
	modport sink (input valid, status, real_x, real_y, real_z, output ready);
endinterface

FILE: design/hpt_mul.sv
// Two-stage signed multiplier built from four registered partial products.
module hpt_mul #(
	parameter int AW = 48,
	parameter int BW = 49
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [AW-1:0]  a,
	input  logic signed [BW-1:0]  b,
	output logic signed [AW+BW-1:0] p
);
	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic        [AL+BL-1:0]  ll_s1;
	logic signed [AL+BH:0]    lh_s1;
	logic signed [AH+BL:0]    hl_s1;
	logic signed [AH+BH-1:0]  hh_s1;
	logic signed [PW-1:0]     ll_x, lh_x, hl_x, hh_x;
	logic signed [PW-1:0]     p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[AL-1:0] * b[BL-1:0];
			lh_s1 <= $signed({1'b0, a[AL-1:0]}) * $signed(b[BW-1:BL]);
			hl_s1 <= $signed(a[AW-1:AL]) * $signed({1'b0, b[BL-1:0]});
			hh_s1 <= $signed(a[AW-1:AL]) * $signed(b[BW-1:BL]);
		end
	end

	assign ll_x = $signed(PW'(ll_s1));
	assign lh_x = PW'(lh_s1) <<< AL;
	assign hl_x = PW'(hl_s1) <<< BL;
	assign hh_x = PW'(hh_s1) <<< (AL + BL);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= ll_x + lh_x + hl_x + hh_x;
		end
	end

	assign p = p_s2;

endmodule

FILE: design/hpt_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module hpt_div #(
	parameter int RW = 163,
	parameter int QW = 48
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RW-1:0] num,
	input  logic [RW-1:0] den,
	output logic [QW-1:0] q
);
	logic [RW-1:0] rem_s [QW];
	logic [RW-1:0] den_s [QW];
	logic [QW-1:0] q_s   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [RW-1:0] rem_in;
		logic [RW-1:0] den_in;
		logic [QW-1:0] q_in;
		logic [RW-1:0] dsh;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign q_in   = q_s[k-1];
		end

		assign dsh = den_in << (QW - 1 - k);

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_in;
				if (rem_in >= dsh) begin
					rem_s[k] <= rem_in - dsh;
					q_s[k]   <= q_in | (QW'(1) << (QW - 1 - k));
				end else begin
					rem_s[k] <= rem_in;
					q_s[k]   <= q_in;
				end
			end
		end
	end

	assign q = q_s[QW-1];

endmodule

FILE: design/homogeneous_point_transform_unit.sv
// Homogeneous 4x4 point transform with perspective divide, top level.
//
// req carries two kinds of transfer. A load (op 0) writes coef_value into
// matrix slot row*4+column (0-15) or origin slot x, y, z (16-18); other
// slots are ignored. A point (op 1) adds the origin, multiplies (x, y, z, 1)
// by the matrix and divides x, y, z by w, truncating toward zero.
// Every request gives exactly one rsp transfer, in order: loads answer with
// status 0 and zero coordinates; points with status 0, 1 when w is zero or
// 2 when a quotient leaves the signed range, coordinates zero unless ok.
// A new request is taken every cycle while no result is held at rsp. From
// the request transfer to rsp.valid the registers are, in order: capture,
// two multiplier stages, row sum, magnitude, range check, one divider stage
// per quotient bit, and the output register.
// A load takes effect for every point that follows it; points in flight
// keep the coefficients they captured.
// When rsp.ready is low with a result waiting, the whole pipeline holds and
// req.ready drops; nothing is lost or repeated.
// Reset loads the identity matrix and a zero origin and empties the pipeline.
module homogeneous_point_transform_unit #(
	parameter int DATA_WIDTH = hpt_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = hpt_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	hpt_in_if.sink    req,
	hpt_out_if.source rsp
);
	localparam int DW  = DATA_WIDTH;
	localparam int SW  = DW + 1;
	localparam int PW  = DW + SW;
	localparam int ACW = PW + 2;
	localparam int RW  = ACW + DW + FRAC_BITS;
	localparam int FW  = hpt_pkg::FIELD_WIDTH;

	localparam logic signed [DW-1:0] ONE_DATA = DW'(128'd1 << FRAC_BITS);
	localparam logic signed [SW-1:0] ONE_SRC  = SW'(128'd1 << FRAC_BITS);

	function automatic logic signed [DW-1:0] fit(input logic signed [FW-1:0] v);
		logic [hpt_pkg::MAX_WIDTH-1:0] e;
		e = hpt_pkg::MAX_WIDTH'(v);
		return e[DW-1:0];
	endfunction

	logic en, acc_in;
	logic signed [DW-1:0] coef_dw;
	logic signed [DW-1:0] pt_in [3];

	logic signed [DW-1:0] matrix_q [16];
	logic signed [DW-1:0] origin_q [3];

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	hpt_pkg::meta_t       meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	logic signed [DW-1:0] mat_s1 [16];
	logic signed [SW-1:0] src_s1 [3];
	logic signed [PW-1:0] prod_s3 [16];
	logic signed [ACW-1:0] acc_s4 [4];
	logic [ACW-1:0]       num_mag_s5 [3];
	logic [ACW-1:0]       den_mag_s5;
	logic [RW-1:0]        rem_s6 [3];
	logic [RW-1:0]        den_s6;
	logic [2:0]           neg_c;
	logic [2:0]           ovf_c;

	logic                 v_dv    [DW];
	hpt_pkg::meta_t       meta_dv [DW];
	logic [DW-1:0]        q_dv [3];

	hpt_pkg::meta_t       meta_out;
	logic [2:0]           ovf_f;
	logic [DW-1:0]        res_f [3];
	hpt_pkg::status_t     st_f;
	logic [FW-1:0]        rx_f, ry_f, rz_f;

	logic                 rsp_v_q;
	hpt_pkg::status_t     rsp_status_q;
	logic [FW-1:0]        rsp_x_q, rsp_y_q, rsp_z_q;

	// Whole pipeline advances unless a result is held at the output
	assign en        = !rsp_v_q || rsp.ready;
	assign req.ready = en;
	assign acc_in    = req.valid && en;

	assign coef_dw  = fit(req.coef_value);
	assign pt_in[0] = fit(req.point_x);
	assign pt_in[1] = fit(req.point_y);
	assign pt_in[2] = fit(req.point_z);

	// Coefficient stores, written as a load transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				matrix_q[i] <= (i % 5 == 0) ? ONE_DATA : '0;
			end
			for (int i = 0; i < 3; i++) begin
				origin_q[i] <= '0;
			end
		end else if (acc_in && req.op == hpt_pkg::OP_LOAD) begin
			if (req.slot < hpt_pkg::SLOT_ORIGIN_X) begin
				matrix_q[req.slot[3:0]] <= coef_dw;
			end else if (req.slot < hpt_pkg::SLOT_END) begin
				origin_q[req.slot[1:0]] <= coef_dw;
			end
		end
	end

	// Valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int k = 0; k < DW; k++) begin
				v_dv[k] <= 1'b0;
			end
			rsp_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_dv[0] <= v_s6;
			for (int k = 1; k < DW; k++) begin
				v_dv[k] <= v_dv[k-1];
			end
			rsp_v_q <= v_dv[DW-1];
		end
	end

	// Stage 1: capture coefficients and the offset point
	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= '{point: req.op == hpt_pkg::OP_POINT, wzero: 1'b0,
				neg: 3'b000, ovf: 3'b000};
			for (int i = 0; i < 16; i++) begin
				mat_s1[i] <= matrix_q[i];
			end
			for (int c = 0; c < 3; c++) begin
				src_s1[c] <= SW'(pt_in[c]) + SW'(origin_q[c]);
			end
		end
	end

	// Stages 2 and 3: sixteen products
	for (genvar r = 0; r < 4; r++) begin : g_row
		for (genvar c = 0; c < 4; c++) begin : g_col
			logic signed [SW-1:0] b_op;
			if (c == 3) begin : g_w
				assign b_op = ONE_SRC;
			end else begin : g_p
				assign b_op = src_s1[c];
			end
			hpt_mul #(.AW(DW), .BW(SW)) u_mul (
				.clk (clk),
				.en  (en),
				.a   (mat_s1[r*4+c]),
				.b   (b_op),
				.p   (prod_s3[r*4+c])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
		end
	end

	// Stage 4: row sums
	always_ff @(posedge clk) begin
		if (en) begin
			meta_s4 <= meta_s3;
			for (int r = 0; r < 4; r++) begin
				acc_s4[r] <= ACW'(prod_s3[r*4]) + ACW'(prod_s3[r*4+1])
					+ ACW'(prod_s3[r*4+2]) + ACW'(prod_s3[r*4+3]);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			neg_c[c] = acc_s4[c][ACW-1] ^ acc_s4[3][ACW-1];
			ovf_c[c] = (RW'(num_mag_s5[c]) << FRAC_BITS) >= (RW'(den_mag_s5) << DW);
		end
	end

	// Stage 5: magnitudes, quotient signs, zero w
	always_ff @(posedge clk) begin
		if (en) begin
			meta_s5 <= '{point: meta_s4.point, wzero: acc_s4[3] == '0,
				neg: neg_c, ovf: meta_s4.ovf};
			for (int c = 0; c < 3; c++) begin
				num_mag_s5[c] <= acc_s4[c][ACW-1] ? ACW'(-acc_s4[c])
					: ACW'(acc_s4[c]);
			end
			den_mag_s5 <= acc_s4[3][ACW-1] ? ACW'(-acc_s4[3]) : ACW'(acc_s4[3]);
		end
	end

	// Stage 6: scale numerators; flag quotients that need more than DW bits
	always_ff @(posedge clk) begin
		if (en) begin
			meta_s6 <= '{point: meta_s5.point, wzero: meta_s5.wzero,
				neg: meta_s5.neg, ovf: ovf_c};
			den_s6  <= RW'(den_mag_s5);
			for (int c = 0; c < 3; c++) begin
				rem_s6[c] <= RW'(num_mag_s5[c]) << FRAC_BITS;
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_lane
		hpt_div #(.RW(RW), .QW(DW)) u_div (
			.clk (clk),
			.en  (en),
			.num (rem_s6[c]),
			.den (den_s6),
			.q   (q_dv[c])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_dv[0] <= meta_s6;
			for (int k = 1; k < DW; k++) begin
				meta_dv[k] <= meta_dv[k-1];
			end
		end
	end

	// Final range check, sign and status
	assign meta_out = meta_dv[DW-1];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ovf_f[c] = meta_out.ovf[c] || (q_dv[c][DW-1]
				&& !(meta_out.neg[c] && q_dv[c][DW-2:0] == '0));
			res_f[c] = meta_out.neg[c] ? DW'(-q_dv[c]) : q_dv[c];
		end
		st_f = hpt_pkg::ST_OK;
		rx_f = '0;
		ry_f = '0;
		rz_f = '0;
		if (meta_out.point) begin
			if (meta_out.wzero) begin
				st_f = hpt_pkg::ST_WZERO;
			end else if (|ovf_f) begin
				st_f = hpt_pkg::ST_OVF;
			end else begin
				rx_f = FW'(res_f[0]);
				ry_f = FW'(res_f[1]);
				rz_f = FW'(res_f[2]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_status_q <= st_f;
			rsp_x_q      <= rx_f;
			rsp_y_q      <= ry_f;
			rsp_z_q      <= rz_f;
		end
	end

	assign rsp.valid  = rsp_v_q;
	assign rsp.status = rsp_status_q;
	assign rsp.real_x = rsp_x_q;
	assign rsp.real_y = rsp_y_q;
	assign rsp.real_z = rsp_z_q;

`ifndef SYNTHESIS
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != hpt_pkg::ST_OK
		|-> rsp.real_x == '0 && rsp.real_y == '0 && rsp.real_z == '0)
		else $error("failed result carries nonzero coordinates");

	a_matrix_write: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in && req.op == hpt_pkg::OP_LOAD && req.slot < hpt_pkg::SLOT_ORIGIN_X
		|=> matrix_q[$past(req.slot[3:0])] == $past(coef_dw))
		else $error("matrix load not stored");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s6) && $stable(v_dv[DW-1]))
		else $error("pipeline moved during a stall");
`endif

endmodule
